### rtl/ampdu_aggregate_packer_core_assert.svh
// Assertion macros used by the packer core RTL.
`ifndef AMPDU_AGGREGATE_PACKER_CORE_ASSERT_SVH
`define AMPDU_AGGREGATE_PACKER_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define AAPK_CHECK(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("aapk check failed");

// Implication with the consequent checked in the cycle after the antecedent.
`define AAPK_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aapk sequence check failed");

`endif

### rtl/aapk_pkg.sv
// ----------------------------------------------------------------------------
// aapk_pkg
// Types, constants and the delimiter CRC used across the A-MPDU packer.
// ----------------------------------------------------------------------------
package aapk_pkg;

    localparam int MAX_FRAMES  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int SEQ_W   = 12;
    localparam int LEN_W   = 12;
    localparam int BYTES_W = 14;
    localparam int WIN_W   = 7;
    localparam int DESC_W  = 8;
    localparam int CNT_W   = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 14;

    localparam logic [WIN_W-1:0]   WINDOW_RESET = 7'd64;
    localparam logic [BYTES_W-1:0] MAXB_RESET   = 14'd8192;
    localparam logic [DESC_W-1:0]  DESC_RESET   = 8'd80;

    localparam logic [7:0] CRC_INIT  = 8'hcf;
    localparam logic [7:0] DELIM_SIG = 8'h4e;
    localparam logic [BYTES_W-1:0] BYTES_MAX = 14'h3fff;

    typedef enum logic [1:0] {
        ST_ACCEPTED    = 2'd0,
        ST_FRAME_LIMIT = 2'd1,
        ST_OUT_WINDOW  = 2'd2,
        ST_BYTE_LIMIT  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE = 8'd0,
        REG_MAX_BYTES   = 8'd1,
        REG_DESC_BYTES  = 8'd2
    } cfg_reg_t;

    // classified MPDU handed from front to back
    typedef struct packed {
        status_t            status;
        logic [LEN_W-1:0]   mpdu_len;
        logic [1:0]         pad_bytes;
        logic [BYTES_W-1:0] offset;
        logic [BYTES_W-1:0] total_bytes;
        logic [CNT_W-1:0]   frame_count;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [31:0]        delimiter;
        logic [1:0]         pad_bytes;
        logic [BYTES_W-1:0] offset;
        logic [BYTES_W-1:0] total_bytes;
        logic [CNT_W-1:0]   frame_count;
        logic [BYTES_W-1:0] on_air_bytes;
    } result_t;

    function automatic logic [7:0] half_crc(input logic [7:0] x);
        logic [7:0] c;
        c = x ^ {x[0], x[7:1]} ^ (x >> 2) ^ ((x << 4) & 8'h30);
        if (x[1])
        begin
            c = c ^ 8'hc0;
        end
        return c;
    endfunction

    function automatic logic [7:0] delim_hdr_crc(input logic [7:0] b0, input logic [7:0] b1);
        logic [7:0] crc;
        crc = CRC_INIT ^ half_crc(b0);
        crc = half_crc(crc) ^ half_crc(b1);
        return ~crc;
    endfunction

endpackage

### rtl/ampdu_aggregate_packer_core.sv
// A result reaches the output ports through the front check into the queue and
// then the delimiter/CRC result register, and can wait in either when stalled.
// Throughput: one MPDU per cycle while the queue is not full, set by the admission
// check and state update in the front half; a 2-entry queue decouples the halves.
// Reset (rst_n low, async): byte total 80, frame count 0, window start 0,
// registers to 64 / 8192 / 80, queue and result register emptied.
// ----------------------------------------------------------------------------
// ampdu_aggregate_packer_core
// A-MPDU admission and delimiter generation, one result per MPDU taken in (push while not full).
// ----------------------------------------------------------------------------
`include "ampdu_aggregate_packer_core_assert.svh"

module ampdu_aggregate_packer_core
    import aapk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  first,
    input  logic [SEQ_W-1:0]      window_start,
    input  logic [SEQ_W-1:0]      seq,
    input  logic [LEN_W-1:0]      mpdu_len,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            status,
    output logic [31:0]           delimiter,
    output logic [1:0]            pad_bytes,
    output logic [BYTES_W-1:0]    offset,
    output logic [BYTES_W-1:0]    total_bytes,
    output logic [CNT_W-1:0]      frame_count,
    output logic [BYTES_W-1:0]    on_air_bytes,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [WIN_W-1:0]   window_size_reg;
    logic [BYTES_W-1:0] max_bytes_reg;
    logic [DESC_W-1:0]  desc_bytes_reg;

    logic    take;
    item_t   front_item;
    item_t   q_head;
    logic    q_empty;
    logic    q_pop;
    logic    out_valid;
    result_t result;
    logic    reject_blank;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_RESET;
            max_bytes_reg   <= MAXB_RESET;
            desc_bytes_reg  <= DESC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_SIZE: window_size_reg <= cfg_data[WIN_W-1:0];
                REG_MAX_BYTES:   max_bytes_reg   <= cfg_data[BYTES_W-1:0];
                REG_DESC_BYTES:  desc_bytes_reg  <= cfg_data[DESC_W-1:0];
                default:         ;
            endcase
        end
    end

    assign take = push && !full;

    aapk_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (take),
        .first            (first),
        .window_start     (window_start),
        .seq              (seq),
        .mpdu_len         (mpdu_len),
        .window_size      (window_size_reg),
        .max_bytes        (max_bytes_reg),
        .descriptor_bytes (desc_bytes_reg),
        .item             (front_item)
    );

    aapk_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (front_item),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .full    (full),
        .empty   (q_empty)
    );

    aapk_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_avail         (!q_empty),
        .in_item          (q_head),
        .in_take          (q_pop),
        .descriptor_bytes (desc_bytes_reg),
        .pop              (pop),
        .out_valid        (out_valid),
        .result           (result)
    );

    assign empty        = !out_valid;
    assign status       = result.status;
    assign delimiter    = result.delimiter;
    assign pad_bytes    = result.pad_bytes;
    assign offset       = result.offset;
    assign total_bytes  = result.total_bytes;
    assign frame_count  = result.frame_count;
    assign on_air_bytes = result.on_air_bytes;

    assign reject_blank = (delimiter == '0) && (pad_bytes == '0) && (offset == '0);

    // accepted transactions carry the signature, rejected ones a blank delimiter
    `AAPK_CHECK(a_sig_on_accept, empty || status != ST_ACCEPTED || delimiter[31:24] == DELIM_SIG)
    `AAPK_CHECK(a_blank_on_reject, empty || status == ST_ACCEPTED || reject_blank)
    `AAPK_CHECK(a_frame_cap, empty || frame_count <= CNT_W'(MAX_FRAMES))
    // a queued item with a free result slot reaches the output in the next cycle
    `AAPK_CHECK_NEXT(a_queue_drains, !q_empty && empty, !empty)

endmodule

### rtl/aapk_front.sv
// ----------------------------------------------------------------------------
// aapk_front
// Aggregate state and admission checks: frame limit, window, byte budget.
// ----------------------------------------------------------------------------
module aapk_front
    import aapk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                first,
    input  logic [SEQ_W-1:0]    window_start,
    input  logic [SEQ_W-1:0]    seq,
    input  logic [LEN_W-1:0]    mpdu_len,
    input  logic [WIN_W-1:0]    window_size,
    input  logic [BYTES_W-1:0]  max_bytes,
    input  logic [DESC_W-1:0]   descriptor_bytes,
    output item_t               item
);

    logic [BYTES_W-1:0] byte_total_reg, byte_total_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SEQ_W-1:0]   start_reg, start_next;

    logic [BYTES_W-1:0] base_total;
    logic [CNT_W-1:0]   base_count;
    logic [SEQ_W-1:0]   base_start;
    logic [WIN_W-1:0]   limit;
    logic [SEQ_W-1:0]   seq_diff;
    logic [LEN_W:0]     slot;
    logic [BYTES_W:0]   sum;
    status_t            status;

    always_comb
    begin
        base_total = first ? {{(BYTES_W-DESC_W){1'b0}}, descriptor_bytes} : byte_total_reg;
        base_count = first ? '0 : count_reg;
        base_start = first ? window_start : start_reg;

        limit    = (window_size < WIN_W'(MAX_FRAMES)) ? window_size : WIN_W'(MAX_FRAMES);
        seq_diff = seq - base_start;
        slot     = ({1'b0, mpdu_len} + (LEN_W+1)'(11)) & ~(LEN_W+1)'(3);
        sum      = {1'b0, base_total} + (BYTES_W+1)'(slot);

        priority if ({{(WIN_W-CNT_W){1'b0}}, base_count} >= limit)
            status = ST_FRAME_LIMIT;
        else if (seq_diff >= {{(SEQ_W-WIN_W){1'b0}}, window_size})
            status = ST_OUT_WINDOW;
        else if (sum > {1'b0, max_bytes})
            status = ST_BYTE_LIMIT;
        else
            status = ST_ACCEPTED;

        if (status == ST_ACCEPTED)
        begin
            byte_total_next = sum[BYTES_W-1:0];
            count_next      = base_count + CNT_W'(1);
        end
        else
        begin
            byte_total_next = base_total;
            count_next      = base_count;
        end
        start_next = base_start;

        item.status      = status;
        item.mpdu_len    = mpdu_len;
        item.pad_bytes   = (status == ST_ACCEPTED) ? 2'(-mpdu_len[1:0]) : 2'd0;
        item.offset      = (status == ST_ACCEPTED) ? base_total : '0;
        item.total_bytes = byte_total_next;
        item.frame_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_total_reg <= {{(BYTES_W-DESC_W){1'b0}}, DESC_RESET};
            count_reg      <= '0;
            start_reg      <= '0;
        end
        else if (take)
        begin
            byte_total_reg <= byte_total_next;
            count_reg      <= count_next;
            start_reg      <= start_next;
        end
    end

endmodule

### rtl/aapk_queue.sv
// ----------------------------------------------------------------------------
// aapk_queue
// Short FIFO of classified items between the front and back halves.
// ----------------------------------------------------------------------------
module aapk_queue
    import aapk_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  item_t wr_data,
    input  logic  rd_en,
    output item_t rd_data,
    output logic  full,
    output logic  empty
);

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/aapk_back.sv
// ----------------------------------------------------------------------------
// aapk_back
// Builds the delimiter with its CRC and the on-air length; holds the result.
// ----------------------------------------------------------------------------
module aapk_back
    import aapk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_avail,
    input  item_t             in_item,
    output logic              in_take,
    input  logic [DESC_W-1:0] descriptor_bytes,
    input  logic              pop,
    output logic              out_valid,
    output result_t           result
);

    logic    out_valid_reg, out_valid_next;
    result_t result_reg;
    result_t built;

    logic [15:0]        field;
    logic [BYTES_W:0]   air_sum;
    logic [BYTES_W:0]   air_diff;

    assign in_take = in_avail && (!out_valid_reg || pop);

    always_comb
    begin
        field    = 16'({{1'b0, in_item.mpdu_len} + (LEN_W+1)'(4), 4'b0000});
        air_sum  = {1'b0, in_item.total_bytes} + (BYTES_W+1)'(4);
        air_diff = air_sum - (BYTES_W+1)'(descriptor_bytes);

        built.status      = in_item.status;
        built.delimiter   = (in_item.status == ST_ACCEPTED)
                          ? {DELIM_SIG, delim_hdr_crc(field[7:0], field[15:8]), field} : '0;
        built.pad_bytes   = in_item.pad_bytes;
        built.offset      = in_item.offset;
        built.total_bytes = in_item.total_bytes;
        built.frame_count = in_item.frame_count;

        // clamp both ways when the descriptor length changed mid-aggregate
        if (air_sum < (BYTES_W+1)'(descriptor_bytes))
            built.on_air_bytes = '0;
        else if (air_diff > {1'b0, BYTES_MAX})
            built.on_air_bytes = BYTES_MAX;
        else
            built.on_air_bytes = air_diff[BYTES_W-1:0];

        if (in_take)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            result_reg <= built;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule
